[rtl/lpgs_pkg.sv]
// shared types and constants for the line pixel gradient shader
package lpgs_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_GRAD_SEL      = 3'd0;
	localparam logic [2:0] REG_ZSHADE_EN     = 3'd1;
	localparam logic [2:0] REG_DEFAULT_COLOR = 3'd2;
	localparam logic [2:0] REG_Z_MIN         = 3'd3;
	localparam logic [2:0] REG_Z_MAX         = 3'd4;
	localparam logic [2:0] REG_CENTER_X      = 3'd5;
	localparam logic [2:0] REG_CENTER_Y      = 3'd6;

	// color mode codes
	localparam logic [1:0] MODE_DEFAULT = 2'd0;
	localparam logic [1:0] MODE_PAIR_A  = 2'd2;

	localparam int unsigned CFG_W   = 24;
	localparam int unsigned IN_W    = 224;
	localparam int unsigned OUT_W   = 24;
	localparam logic [23:0] WHITE   = 24'hFFFFFF;

	// registered configuration
	typedef struct packed {
		logic [1:0]         grad_sel;
		logic               zshade_en;
		logic [23:0]        default_color;
		logic signed [15:0] z_min;
		logic signed [15:0] z_max;
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
	} cfg_t;

	// one unpacked input request
	typedef struct packed {
		logic signed [15:0] pixel_y;
		logic signed [15:0] pixel_x;
		logic signed [15:0] line_dy;
		logic signed [15:0] line_dx;
		logic [23:0]        end_color_b;
		logic [23:0]        end_color_a;
		logic [23:0]        start_color_b;
		logic [23:0]        start_color_a;
		logic signed [15:0] end_z;
		logic signed [15:0] start_z;
		logic signed [15:0] start_y;
		logic signed [15:0] start_x;
	} req_t;

endpackage

[rtl/lpgs_div.sv]
// pipelined restoring divider, one quotient bit per stage, with stall
module lpgs_div #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 33,
	parameter int Q_W   = 34,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  rem_init,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] side_out
);
	// remainder starts at rem_init (kept below den), then the Q_W bits of num
	// shift in msb first
	localparam int R_W = DEN_W + 1;
	localparam int SH_W = Q_W;

	logic [R_W-1:0]    rem_s  [Q_W+1];
	logic [SH_W-1:0]   sh_s   [Q_W+1];
	logic [Q_W-1:0]    q_s    [Q_W+1];
	logic [DEN_W-1:0]  den_s  [Q_W+1];
	logic [SIDE_W-1:0] side_s [Q_W+1];
	logic [Q_W:0]      vld_s;

	assign rem_s[0]  = R_W'(rem_init);
	assign sh_s[0]   = SH_W'(num);
	assign q_s[0]    = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_valid;

	genvar g;
	generate
		for (g = 0; g < Q_W; g++) begin : g_stage
			logic [R_W-1:0] trial;
			logic [R_W:0]   diff;
			assign trial = {rem_s[g][R_W-2:0], sh_s[g][SH_W-1]};
			assign diff  = {1'b0, trial} - {2'b0, den_s[g]};
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g+1] <= 1'b0;
				end else if (en) begin
					vld_s[g+1] <= vld_s[g];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1]  <= diff[R_W] ? trial : diff[R_W-1:0];
					sh_s[g+1]   <= {sh_s[g][SH_W-2:0], 1'b0};
					q_s[g+1]    <= {q_s[g][Q_W-2:0], ~diff[R_W]};
					den_s[g+1]  <= den_s[g];
					side_s[g+1] <= side_s[g];
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[Q_W];
	assign quo       = q_s[Q_W];
	assign side_out  = side_s[Q_W];
endmodule

[rtl/lpgs_sqrt.sv]
// pipelined integer square root, one result bit per stage, with stall
module lpgs_sqrt #(
	parameter int IN_W   = 32,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [IN_W/2-1:0] root,
	output logic [SIDE_W-1:0] side_out
);
	localparam int N = IN_W / 2;
	localparam int R_W = N + 2;

	logic [R_W-1:0]    rem_s  [N+1];
	logic [IN_W-1:0]   sh_s   [N+1];
	logic [N-1:0]      q_s    [N+1];
	logic [SIDE_W-1:0] side_s [N+1];
	logic [N:0]        vld_s;

	assign rem_s[0]  = '0;
	assign sh_s[0]   = rad;
	assign q_s[0]    = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_valid;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_stage
			// classic digit recurrence: trial = rem*4 + next pair, test 4q+1
			logic [R_W-1:0] trial;
			logic [R_W-1:0] sub;
			logic [R_W:0]   diff;
			assign trial = {rem_s[g][R_W-3:0], sh_s[g][IN_W-1 -: 2]};
			assign sub   = R_W'({q_s[g], 2'b01});
			assign diff  = {1'b0, trial} - {1'b0, sub};
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g+1] <= 1'b0;
				end else if (en) begin
					vld_s[g+1] <= vld_s[g];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1]  <= diff[R_W] ? trial : diff[R_W-1:0];
					sh_s[g+1]   <= {sh_s[g][IN_W-3:0], 2'b00};
					q_s[g+1]    <= {q_s[g][N-2:0], ~diff[R_W]};
					side_s[g+1] <= side_s[g];
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[N];
	assign root      = q_s[N];
	assign side_out  = side_s[N];
endmodule

[rtl/line_pixel_gradient_shader_top.sv]
// top level of the line pixel gradient shader pipeline
// Takes one line pixel request per clock and returns its RGB888 color. The
// path is a fixed pipeline: offsets, squares and sums (3 stages), a
// one-bit-per-stage divider for d2/l2 (2*FRAC_BITS stages), a square root
// (FRAC_BITS stages), a blend and shade numerator stage, a second divider for
// the shade (FRAC_BITS+19 stages) and the scaling output register. Throughput
// is one request per cycle while the output is not stalled. The whole pipe
// advances when the output register is empty or being taken, so a stall at
// the output holds every stage.
module line_pixel_gradient_shader_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// config write port
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [lpgs_pkg::CFG_W-1:0] cfg_wdata,
	// request stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// start_x, start_y, start_z, end_z, start_color_a, start_color_b,
	// end_color_a, end_color_b, line_dx, line_dy, pixel_x, pixel_y
	input  logic [lpgs_pkg::IN_W-1:0] s_tdata,
	// result stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// pixel_color
	output logic [lpgs_pkg::OUT_W-1:0] m_tdata
);
	import lpgs_pkg::*;

	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
	localparam int DQ_W  = 2 * FRAC_BITS;  // quotient bits of d2/l2 fraction
	localparam int SN_W  = 17 + FRAC_BITS + 2; // shade numerator magnitude

	cfg_t cfg_q;
	logic en;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grad_sel      <= MODE_DEFAULT;
			cfg_q.zshade_en     <= 1'b0;
			cfg_q.default_color <= WHITE;
			cfg_q.z_min         <= '0;
			cfg_q.z_max         <= '0;
			cfg_q.center_x      <= '0;
			cfg_q.center_y      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRAD_SEL:      cfg_q.grad_sel      <= cfg_wdata[1:0];
				REG_ZSHADE_EN:     cfg_q.zshade_en     <= cfg_wdata[0];
				REG_DEFAULT_COLOR: cfg_q.default_color <= cfg_wdata[23:0];
				REG_Z_MIN:         cfg_q.z_min         <= cfg_wdata[15:0];
				REG_Z_MAX:         cfg_q.z_max         <= cfg_wdata[15:0];
				REG_CENTER_X:      cfg_q.center_x      <= cfg_wdata[15:0];
				REG_CENTER_Y:      cfg_q.center_y      <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// pipe advances whenever the output slot is free or taken
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	req_t req;
	assign req = req_t'(s_tdata);

	// color and depth data that rides along the fraction path
	typedef struct packed {
		logic [23:0]        c0;
		logic [23:0]        c1;
		logic               use_dflt;
		logic signed [15:0] sz;
		logic signed [15:0] ez;
	} side_t;

	// stage 1: offsets
	logic               v_s1;
	logic signed [17:0] ex_s1, ey_s1;
	logic signed [15:0] dx_s1, dy_s1;
	side_t              sd_s1;
	side_t              sd_in;

	always_comb begin
		sd_in.use_dflt = (cfg_q.grad_sel == MODE_DEFAULT);
		sd_in.c0 = (cfg_q.grad_sel == MODE_PAIR_A) ? req.start_color_a
			: req.start_color_b;
		sd_in.c1 = (cfg_q.grad_sel == MODE_PAIR_A) ? req.end_color_a
			: req.end_color_b;
		sd_in.sz = req.start_z;
		sd_in.ez = req.end_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1 <= 18'(req.pixel_x) - 18'(cfg_q.center_x) - 18'(req.start_x);
			ey_s1 <= 18'(req.pixel_y) - 18'(cfg_q.center_y) - 18'(req.start_y);
			dx_s1 <= req.line_dx;
			dy_s1 <= req.line_dy;
			sd_s1 <= sd_in;
		end
	end

	// stage 2: squares
	logic        v_s2;
	logic [35:0] ex2_s2, ey2_s2;
	logic [31:0] dx2_s2, dy2_s2;
	side_t       sd_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ex2_s2 <= 36'(ex_s1 * ex_s1);
			ey2_s2 <= 36'(ey_s1 * ey_s1);
			dx2_s2 <= 32'(dx_s1 * dx_s1);
			dy2_s2 <= 32'(dy_s1 * dy_s1);
			sd_s2  <= sd_s1;
		end
	end

	// stage 3: sums and special cases
	logic        v_s3;
	logic [36:0] d2_s3;
	logic [32:0] l2_s3;
	logic        zero_s3, sat_s3;
	side_t       sd_s3;
	logic [36:0] d2_c;
	logic [32:0] l2_c;
	assign d2_c = 37'(ex2_s2) + 37'(ey2_s2);
	assign l2_c = 33'(dx2_s2) + 33'(dy2_s2);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3   <= d2_c;
			l2_s3   <= l2_c;
			zero_s3 <= (l2_c == '0);
			sat_s3  <= (d2_c >= 37'(l2_c));
			sd_s3   <= sd_s2;
		end
	end

	// divide d2/l2 with 2*FRAC_BITS fraction bits (d2 < l2 when used):
	// d2 seeds the remainder and zeros shift in
	typedef struct packed {
		side_t sd;
		logic  zero;
		logic  sat;
	} fside_t;
	localparam int FS_W = $bits(fside_t);
	fside_t fs_in, fs_div, fs_sq;
	logic   v_div, v_sq;
	logic [DQ_W-1:0] q_div;
	logic [FRAC_BITS-1:0] root;

	assign fs_in = '{sd: sd_s3, zero: zero_s3, sat: sat_s3};

	lpgs_div #(
		.NUM_W(DQ_W), .DEN_W(33), .Q_W(DQ_W), .SIDE_W(FS_W)
	) u_fdiv (
		.clk, .arst_n, .en,
		.in_valid (v_s3),
		.num      ('0),
		.rem_init (d2_s3[32:0]),
		.den      (l2_s3),
		.side_in  (fs_in),
		.out_valid(v_div),
		.quo      (q_div),
		.side_out (fs_div)
	);

	lpgs_sqrt #(.IN_W(DQ_W), .SIDE_W(FS_W)) u_sqrt (
		.clk, .arst_n, .en,
		.in_valid (v_div),
		.rad      (q_div),
		.side_in  (fs_div),
		.out_valid(v_sq),
		.root     (root),
		.side_out (fs_sq)
	);

	// stage 4: fraction, channel blend, shade numerator
	logic [FRAC_BITS:0] f_c;
	assign f_c = fs_sq.zero ? '0 : fs_sq.sat ? ONE : (FRAC_BITS+1)'(root);

	logic                 v_s4;
	logic [23:0]          col_s4;
	logic                 neg_s4;
	logic [SN_W-1:0]      num_s4;
	logic [16:0]          den_s4;
	logic                 zden_s4;
	logic [23:0]          blend_c;
	logic signed [SN_W+1:0] num_c;
	logic signed [FRAC_BITS+1:0] fq_c;
	logic signed [16:0]   dz_c;
	logic signed [FRAC_BITS+18:0] prod_c;
	logic signed [16:0]   den_c;
	logic                 flip_c;
	logic signed [SN_W+1:0] nadj_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			blend_c[k*8 +: 8] = 8'(((FRAC_BITS+9)'(f_c) * fs_sq.sd.c1[k*8 +: 8]
				+ (FRAC_BITS+9)'(ONE - f_c) * fs_sq.sd.c0[k*8 +: 8]) >> FRAC_BITS);
		end
		if (fs_sq.sd.c0 == fs_sq.sd.c1) blend_c = fs_sq.sd.c0;
		if (fs_sq.sd.use_dflt) blend_c = cfg_q.default_color;
		fq_c   = $signed({1'b0, f_c});
		dz_c   = 17'(fs_sq.sd.ez) - 17'(fs_sq.sd.sz);
		prod_c = fq_c * dz_c;
		num_c = ((SN_W+2)'(fs_sq.sd.sz) - (SN_W+2)'(cfg_q.z_min)) <<< FRAC_BITS;
		num_c = num_c + (SN_W+2)'(prod_c);
		den_c  = 17'(cfg_q.z_max) - 17'(cfg_q.z_min);
		flip_c = den_c[16];
		nadj_c = flip_c ? -num_c : num_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_sq;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			col_s4  <= blend_c;
			neg_s4  <= (nadj_c <= 0);
			num_s4  <= SN_W'(nadj_c);
			den_s4  <= flip_c ? 17'(-den_c) : 17'(den_c);
			zden_s4 <= (den_c == '0);
		end
	end

	// shade divider
	typedef struct packed {
		logic [23:0] col;
		logic        neg;
		logic        zden;
	} sside_t;
	sside_t ss_in, ss_out;
	logic   v_sd;
	logic [SN_W-1:0] q_sh;
	assign ss_in = '{col: col_s4, neg: neg_s4, zden: zden_s4};

	lpgs_div #(
		.NUM_W(SN_W), .DEN_W(17), .Q_W(SN_W), .SIDE_W($bits(sside_t))
	) u_zdiv (
		.clk, .arst_n, .en,
		.in_valid (v_s4),
		.num      (num_s4),
		.rem_init ('0),
		.den      (den_s4),
		.side_in  (ss_in),
		.out_valid(v_sd),
		.quo      (q_sh),
		.side_out (ss_out)
	);

	// output stage: shade saturation and scale
	logic [FRAC_BITS:0] shade_c;
	logic [23:0]        out_c;
	always_comb begin
		if (ss_out.zden) shade_c = ONE;
		else if (ss_out.neg) shade_c = '0;
		else if (q_sh > SN_W'(ONE)) shade_c = ONE;
		else shade_c = (FRAC_BITS+1)'(q_sh);
		for (int k = 0; k < 3; k++) begin
			out_c[k*8 +: 8] = 8'(((FRAC_BITS+9)'(ss_out.col[k*8 +: 8])
				* (FRAC_BITS+9)'(shade_c)) >> FRAC_BITS);
		end
		if (!cfg_q.zshade_en) out_c = ss_out.col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= v_sd;
	end
	always_ff @(posedge clk) begin
		if (en) m_tdata <= out_c;
	end

	// checks
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output slot");
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped under stall");
endmodule
